FILE: rtl/sm3hc_pkg.sv
`default_nettype none
package sm3hc_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic        new_message;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] hash_word_0;
    logic [31:0] hash_word_1;
    logic [31:0] hash_word_2;
    logic [31:0] hash_word_3;
    logic [31:0] hash_word_4;
    logic [31:0] hash_word_5;
    logic [31:0] hash_word_6;
    logic [31:0] hash_word_7;
  } hash_item_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_ROUND,
    ST_FINISH
  } sm3hc_state_t;

  typedef struct packed {
    logic       load_word;
    logic [3:0] word_idx;
    logic       reload_iv;
    logic       start_rounds;
    logic       do_round;
    logic       low_rounds;
    logic       t_switch;
    logic       finish;
  } sm3hc_cmd_t;

  typedef struct packed {
    logic out_free;
  } sm3hc_status_t;

  localparam logic [3:0] LAST_WORD_IDX = 4'd15;
  localparam logic [5:0] LAST_ROUND    = 6'd63;
  localparam logic [5:0] T_SWITCH_RND  = 6'd15;

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;

  localparam logic [31:0] SM3_IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

endpackage
`default_nettype wire

FILE: rtl/sm3hc_ctrl.sv
`default_nettype none
module sm3hc_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   msg_valid,
  input  wire logic                   new_message,
  input  wire sm3hc_pkg::sm3hc_status_t status,
  output logic                        msg_ready,
  output sm3hc_pkg::sm3hc_cmd_t       cmd
);
  import sm3hc_pkg::*;

  sm3hc_state_t state;
  sm3hc_state_t state_next;
  logic [5:0]   cnt;
  logic [5:0]   cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    msg_ready        = (state == ST_COLLECT);
    cmd              = '0;
    cmd.load_word    = msg_ready && msg_valid;
    cmd.word_idx     = new_message ? 4'd0 : cnt[3:0];
    cmd.reload_iv    = cmd.load_word && new_message;
    cmd.start_rounds = cmd.load_word && (cmd.word_idx == LAST_WORD_IDX);
    cmd.do_round     = (state == ST_ROUND);
    cmd.low_rounds   = (cnt[5:4] == 2'd0);
    cmd.t_switch     = (cnt == T_SWITCH_RND);
    cmd.finish       = (state == ST_FINISH) && status.out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (cmd.start_rounds) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (cnt == LAST_ROUND) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) state_next = ST_COLLECT;
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    cnt_next = cnt;
    if (cmd.load_word) begin
      cnt_next = cmd.start_rounds ? 6'd0 : {2'b00, cmd.word_idx + 4'd1};
    end else if (cmd.do_round) begin
      cnt_next = cnt + 6'd1;
    end else if (state == ST_FINISH) begin
      cnt_next = '0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sm3hc_datapath.sv
`default_nettype none
module sm3hc_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sm3hc_pkg::sm3hc_cmd_t cmd,
  input  wire logic [31:0]           word,
  input  wire logic                  hash_ready,
  output sm3hc_pkg::sm3hc_status_t   status,
  output logic                       hash_valid,
  output sm3hc_pkg::hash_item_t      hash
);
  import sm3hc_pkg::*;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl32(x, 9) ^ rotl32(x, 17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl32(x, 15) ^ rotl32(x, 23);
  endfunction

  logic [31:0] win [16];
  logic [31:0] cv  [8];
  logic [31:0] v   [8];
  logic [31:0] tj;

  logic [31:0] w_new;
  logic [31:0] a12;
  logic [31:0] ss1;
  logic [31:0] ss2;
  logic [31:0] ff;
  logic [31:0] gg;
  logic [31:0] tt1;
  logic [31:0] tt2;
  logic [31:0] cv_fin [8];

  always_comb begin
    w_new = perm1(win[0] ^ win[7] ^ rotl32(win[13], 15)) ^ rotl32(win[3], 7) ^ win[10];
    a12   = rotl32(v[0], 12);
    ss1   = rotl32(a12 + v[4] + tj, 7);
    ss2   = ss1 ^ a12;
    ff    = cmd.low_rounds ? (v[0] ^ v[1] ^ v[2])
                           : ((v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]));
    gg    = cmd.low_rounds ? (v[4] ^ v[5] ^ v[6]) : ((v[4] & v[5]) | (~v[4] & v[6]));
    tt1   = ff + v[3] + ss2 + (win[0] ^ win[4]);
    tt2   = gg + v[7] + ss1 + win[0];
    for (int k = 0; k < 8; k++) begin
      cv_fin[k] = cv[k] ^ v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_word) begin
      win[cmd.word_idx] <= word;
    end else if (cmd.do_round) begin
      for (int k = 0; k < 15; k++) begin
        win[k] <= win[k + 1];
      end
      win[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_rounds) begin
      for (int k = 0; k < 8; k++) begin
        v[k] <= cmd.reload_iv ? SM3_IV[k] : cv[k];
      end
      tj <= T_LOW;
    end else if (cmd.do_round) begin
      v[0] <= tt1;
      v[1] <= v[0];
      v[2] <= rotl32(v[1], 9);
      v[3] <= v[2];
      v[4] <= perm0(tt2);
      v[5] <= v[4];
      v[6] <= rotl32(v[5], 19);
      v[7] <= v[6];
      tj   <= cmd.t_switch ? rotl32(T_HIGH, 16) : rotl32(tj, 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= SM3_IV;
    end else if (cmd.reload_iv) begin
      cv <= SM3_IV;
    end else if (cmd.finish) begin
      cv <= cv_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      hash <= {cv_fin[0], cv_fin[1], cv_fin[2], cv_fin[3],
               cv_fin[4], cv_fin[5], cv_fin[6], cv_fin[7]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_valid <= 1'b0;
    end else if (cmd.finish) begin
      hash_valid <= 1'b1;
    end else if (hash_ready) begin
      hash_valid <= 1'b0;
    end
  end

  assign status.out_free = !hash_valid || hash_ready;

endmodule
`default_nettype wire

FILE: rtl/sm3_hash_compression_top.sv
// Channel | Direction | Handshake             | Payload
// msg     | in        | msg_valid / msg_ready | msg_item_t  (message_word, new_message)
// hash    | out       | hash_valid/hash_ready | hash_item_t (hash_word_0 .. hash_word_7)
//
// A block takes 16 msg transactions, one per cycle at most, then 64 SM3 rounds
// (one SM3 round per cycle in the datapath) and a finish step. msg_ready is low
// during the rounds and the finish step. The finish step waits while the previous
// hash transaction is still unaccepted. Synchronous reset loads the SM3 initial
// value and clears the word position.
`default_nettype none
module sm3_hash_compression_top (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  msg_valid,
  output logic                       msg_ready,
  input  wire sm3hc_pkg::msg_item_t  msg,
  output logic                       hash_valid,
  input  wire logic                  hash_ready,
  output sm3hc_pkg::hash_item_t      hash
);
  import sm3hc_pkg::*;

  sm3hc_cmd_t    cmd;
  sm3hc_status_t status;

  sm3hc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .msg_valid   (msg_valid),
    .new_message (msg.new_message),
    .status      (status),
    .msg_ready   (msg_ready),
    .cmd         (cmd)
  );

  sm3hc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .word       (msg.message_word),
    .hash_ready (hash_ready),
    .status     (status),
    .hash_valid (hash_valid),
    .hash       (hash)
  );

endmodule
`default_nettype wire

FILE: rtl/sm3hc_checker.sv
`default_nettype none
module sm3hc_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  msg_valid,
  input wire logic                  msg_ready,
  input wire logic                  hash_valid,
  input wire logic                  hash_ready,
  input wire sm3hc_pkg::hash_item_t hash
);

  a_reset_idle: assert property (@(posedge clk) rst |=> (!hash_valid && msg_ready))
    else $error("not idle after reset");

  a_hash_hold: assert property (@(posedge clk) disable iff (rst)
    (hash_valid && !hash_ready) |=> (hash_valid && $stable(hash)))
    else $error("hash transaction dropped or changed while stalled");

  a_rounds_busy: assert property (@(posedge clk) disable iff (rst)
    $fell(msg_ready) |-> ##63 !msg_ready)
    else $error("msg_ready returned before all rounds ran");

  a_result_after_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(hash_valid) |-> $past(!msg_ready))
    else $error("hash transaction raised outside a finish cycle");

  a_msg_seen: assert property (@(posedge clk) disable iff (rst)
    $fell(msg_ready) |-> $past(msg_valid))
    else $error("block started without a msg transaction");

endmodule

bind sm3_hash_compression_top sm3hc_checker u_checker (.*);
`default_nettype wire
